[rtl/core/fmm_pkg.sv]
// Shared types and constants of the FIFO mutex lock manager.
package fmm_pkg;

  localparam int TASK_W = 6;
  localparam int RES_ID_W = 4;
  localparam int NUM_RESOURCES_DEF = 16;
  localparam int WAIT_DEPTH_DEF = 16;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_IDLE     = 3'd3,
    ST_HANDOVER = 3'd4
  } status_t;

  typedef struct packed {
    op_t                 op;
    logic [TASK_W-1:0]   task_id;
    logic [RES_ID_W-1:0] resource_id;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [TASK_W-1:0] woken_task;
  } rsp_t;

endpackage

[rtl/core/fmm_res_store.sv]
// Per-resource lock state memory with valid bits that make unwritten entries read as zero.
module fmm_res_store #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 20,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

[rtl/core/fmm_wait_ram.sv]
// Wait slot memory holding the queued task ids of all resources.
module fmm_wait_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 6,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/fifo_mutex_manager.sv]
// Top level of the FIFO mutex lock manager with its control sequencer.
// A transaction reads the resource's entry from the state memory when it is accepted; the
// sequencer then decides, writes the entry back and registers the result.
// A release that hands the lock to a waiter adds a handover step, since the wait slot memory can
// only be read once the queue head has come out of the state memory. A result that is not
// taken holds the sequencer in its last step. The state memory clears through valid bits
// at reset, so the block accepts transactions as soon as reset is released.
module fifo_mutex_manager #(
  parameter int NUM_RESOURCES = fmm_pkg::NUM_RESOURCES_DEF,
  parameter int WAIT_DEPTH    = fmm_pkg::WAIT_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  fmm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output fmm_pkg::rsp_t rsp
);

  import fmm_pkg::*;

  localparam int RES_W  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int SLOT_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WAIT_DEPTH + 1);
  localparam int SLOTS  = NUM_RESOURCES * WAIT_DEPTH;
  localparam int SA_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef struct packed {
    logic              locked;
    logic [TASK_W-1:0] owner;
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] tail;
    logic [CNT_W-1:0]  count;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_HAND
  } state_t;

  state_t            state;
  req_t              item_q;
  logic              in_rng_q;
  logic              acc;
  logic              in_rng;
  logic              out_free;
  logic              emit;
  status_t           res_status;
  logic [TASK_W-1:0] res_woken;
  logic [RES_W-1:0]  res_q;
  ent_t              cur;
  ent_t              st_wdata;
  logic              st_we;
  logic [ENT_W-1:0]  st_rdata;
  logic              sl_re;
  logic              sl_we;
  logic [SA_W-1:0]   sl_base;
  logic [TASK_W-1:0] sl_rdata;
  logic [SLOT_W-1:0] head_next;
  logic [SLOT_W-1:0] tail_next;

  assign req_ready = (state == S_IDLE);
  assign acc       = req_valid && req_ready;
  assign in_rng    = int'(req.resource_id) < NUM_RESOURCES;
  assign out_free  = !rsp_valid || rsp_ready;
  assign res_q     = RES_W'(item_q.resource_id);
  assign cur       = ent_t'(st_rdata);
  assign sl_base   = SA_W'(res_q) * SA_W'(WAIT_DEPTH);
  assign head_next = (cur.head == SLOT_W'(WAIT_DEPTH - 1)) ? '0 : cur.head + 1'b1;
  assign tail_next = (cur.tail == SLOT_W'(WAIT_DEPTH - 1)) ? '0 : cur.tail + 1'b1;

  fmm_res_store #(
    .DEPTH  (NUM_RESOURCES),
    .WIDTH  (ENT_W),
    .ADDR_W (RES_W)
  ) u_res_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (acc && in_rng),
    .rd_addr (RES_W'(req.resource_id)),
    .rd_data (st_rdata),
    .wr_en   (st_we),
    .wr_addr (res_q),
    .wr_data (ENT_W'(st_wdata))
  );

  fmm_wait_ram #(
    .DEPTH  (SLOTS),
    .WIDTH  (TASK_W),
    .ADDR_W (SA_W)
  ) u_wait_ram (
    .clk     (clk),
    .rd_en   (sl_re),
    .rd_addr (sl_base + SA_W'(cur.head)),
    .rd_data (sl_rdata),
    .wr_en   (sl_we),
    .wr_addr (sl_base + SA_W'(cur.tail)),
    .wr_data (item_q.task_id)
  );

  always_comb begin
    st_wdata   = cur;
    st_we      = 1'b0;
    sl_we      = 1'b0;
    sl_re      = 1'b0;
    emit       = 1'b0;
    res_status = ST_IDLE;
    res_woken  = '0;
    case (state)
      S_EVAL: begin
        if (!in_rng_q) begin
          emit       = out_free;
          res_status = (item_q.op == OP_RELEASE) ? ST_IDLE : ST_FULL;
        end else if (item_q.op == OP_ACQUIRE) begin
          emit = out_free;
          if (!cur.locked) begin
            res_status      = ST_GRANTED;
            st_wdata.locked = 1'b1;
            st_wdata.owner  = item_q.task_id;
            st_we           = out_free;
          end else if (cur.count == CNT_W'(WAIT_DEPTH)) begin
            res_status = ST_FULL;
          end else begin
            res_status     = ST_QUEUED;
            st_wdata.tail  = tail_next;
            st_wdata.count = cur.count + 1'b1;
            st_we          = out_free;
            sl_we          = out_free;
          end
        end else if (cur.count != '0) begin
          sl_re = 1'b1;
        end else begin
          emit            = out_free;
          res_status      = ST_IDLE;
          st_wdata.locked = 1'b0;
          st_wdata.owner  = '0;
          st_we           = out_free;
        end
      end
      S_HAND: begin
        emit            = out_free;
        res_status      = ST_HANDOVER;
        res_woken       = sl_rdata;
        st_wdata.locked = 1'b1;
        st_wdata.owner  = sl_rdata;
        st_wdata.head   = head_next;
        st_wdata.count  = cur.count - 1'b1;
        st_we           = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (sl_re) begin
            state <= S_HAND;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_HAND: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      item_q   <= req;
      in_rng_q <= in_rng;
    end
    if (emit) begin
      rsp.status     <= res_status;
      rsp.woken_task <= res_woken;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(acc && (st_we || sl_we)))
    else $error("State memory written in the cycle a transaction is accepted.");

  assert property (@(posedge clk) disable iff (rst)
    state == S_HAND |-> $past(state) == S_EVAL || $past(state) == S_HAND)
    else $error("Handover step entered without evaluating the resource entry.");

  assert property (@(posedge clk) disable iff (rst) $rose(rsp_valid) |-> $past(state) != S_IDLE)
    else $error("Result raised with no transaction in progress.");

  assert property (@(posedge clk) disable iff (rst) st_we |-> st_wdata.count <= CNT_W'(WAIT_DEPTH))
    else $error("Wait queue count written beyond the queue depth.");

endmodule

[tb/sv/tb_fifo_mutex_manager.sv]
// Self-checking testbench for the FIFO mutex lock manager.
`timescale 1ns / 100ps

module tb_fifo_mutex_manager;
  import fmm_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RANDOM_ITEMS = 915;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 200;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_CAP    = 50;
  localparam int DIR_ROWS     = 18;
  localparam int DUE_DEPTH    = 8;

  typedef struct packed {
    op_t         op;
    logic [5:0]  task_id;
    logic [3:0]  res;
    logic [4:0]  reps;
    logic        typed;
    status_t     status;
    logic [5:0]  woken;
  } dir_row_t;

  dir_row_t directed [DIR_ROWS] = '{
    '{OP_RELEASE, 6'd0,  4'd0,  5'd1,  1'b1, ST_IDLE,     6'd0},
    '{OP_ACQUIRE, 6'd63, 4'd15, 5'd1,  1'b1, ST_GRANTED,  6'd0},
    '{OP_ACQUIRE, 6'd0,  4'd15, 5'd1,  1'b1, ST_QUEUED,   6'd0},
    '{OP_ACQUIRE, 6'd63, 4'd15, 5'd1,  1'b1, ST_QUEUED,   6'd0},
    '{OP_RELEASE, 6'd5,  4'd15, 5'd1,  1'b1, ST_HANDOVER, 6'd0},
    '{OP_RELEASE, 6'd0,  4'd15, 5'd1,  1'b1, ST_HANDOVER, 6'd63},
    '{OP_RELEASE, 6'd63, 4'd15, 5'd1,  1'b1, ST_IDLE,     6'd0},
    '{OP_RELEASE, 6'd63, 4'd15, 5'd1,  1'b1, ST_IDLE,     6'd0},
    '{OP_ACQUIRE, 6'd42, 4'd0,  5'd1,  1'b1, ST_GRANTED,  6'd0},
    '{OP_ACQUIRE, 6'd21, 4'd0,  5'd1,  1'b1, ST_QUEUED,   6'd0},
    '{OP_ACQUIRE, 6'd32, 4'd0,  5'd15, 1'b1, ST_QUEUED,   6'd0},
    '{OP_ACQUIRE, 6'd60, 4'd0,  5'd1,  1'b1, ST_FULL,     6'd0},
    '{OP_RELEASE, 6'd42, 4'd0,  5'd1,  1'b1, ST_HANDOVER, 6'd21},
    '{OP_ACQUIRE, 6'd13, 4'd0,  5'd1,  1'b1, ST_QUEUED,   6'd0},
    '{OP_ACQUIRE, 6'd14, 4'd0,  5'd1,  1'b1, ST_FULL,     6'd0},
    '{OP_RELEASE, 6'd0,  4'd0,  5'd4,  1'b0, ST_IDLE,     6'd0},
    '{OP_ACQUIRE, 6'd7,  4'd5,  5'd1,  1'b1, ST_GRANTED,  6'd0},
    '{OP_RELEASE, 6'd7,  4'd5,  5'd1,  1'b1, ST_IDLE,     6'd0}
  };

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_ready;
  req_t  req       = '0;
  logic  rsp_valid;
  logic  rsp_ready = 1'b0;
  rsp_t  rsp;

  logic                held    [NUM_RESOURCES_DEF];
  logic [TASK_W-1:0]   holder  [NUM_RESOURCES_DEF];
  logic [TASK_W-1:0]   waiters [NUM_RESOURCES_DEF][WAIT_DEPTH_DEF];
  int                  q_head  [NUM_RESOURCES_DEF];
  int                  q_tail  [NUM_RESOURCES_DEF];
  int                  q_count [NUM_RESOURCES_DEF];

  rsp_t answers_due [DUE_DEPTH];
  int   due_wr        = 0;
  int   due_rd        = 0;
  int   status_hits [5];
  int   deepest_queue = 0;
  int   reqs_taken    = 0;
  int   mismatches    = 0;
  int   cycles        = 0;

  fifo_mutex_manager u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int idle_gap();
    int dice;
    dice = $urandom_range(0, 99);
    if (dice < 45) return 0;
    if (dice < 85) return $urandom_range(1, 3);
    if (dice < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic rsp_t arbitrate_lock(req_t item);
    rsp_t ans;
    int   r;
    r = int'(item.resource_id);
    ans.status = ST_IDLE;
    ans.woken_task = '0;
    if (item.op == OP_ACQUIRE) begin
      if (!held[r]) begin
        held[r] = 1'b1;
        holder[r] = item.task_id;
        ans.status = ST_GRANTED;
      end else if (q_count[r] >= WAIT_DEPTH_DEF) begin
        ans.status = ST_FULL;
      end else begin
        waiters[r][q_tail[r]] = item.task_id;
        q_tail[r] = (q_tail[r] + 1) % WAIT_DEPTH_DEF;
        q_count[r]++;
        if (q_count[r] > deepest_queue) deepest_queue = q_count[r];
        ans.status = ST_QUEUED;
      end
    end else begin
      held[r] = 1'b0;
      holder[r] = '0;
      if (q_count[r] > 0) begin
        held[r] = 1'b1;
        holder[r] = waiters[r][q_head[r]];
        q_head[r] = (q_head[r] + 1) % WAIT_DEPTH_DEF;
        q_count[r]--;
        ans.woken_task = holder[r];
        ans.status = ST_HANDOVER;
      end
    end
    return ans;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic offer_request(req_t item, bit eager, bit typed, rsp_t typed_rsp);
    int   gap;
    rsp_t predicted;
    gap = eager ? 0 : idle_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    predicted = arbitrate_lock(item);
    status_hits[predicted.status]++;
    answers_due[due_wr % DUE_DEPTH] = typed ? typed_rsp : predicted;
    due_wr++;
    reqs_taken++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin : watch_rsp
    rsp_t due;
    if (!rst && rsp_valid && rsp_ready) begin
      if (due_wr == due_rd) begin
        note_mismatch("result arrived with no transaction outstanding");
      end else begin
        due = answers_due[due_rd % DUE_DEPTH];
        due_rd++;
        if (rsp.status !== due.status)
          note_mismatch($sformatf("status %0d, expected %0d", rsp.status, due.status));
        if (rsp.woken_task !== due.woken_task)
          note_mismatch($sformatf("woken_task %0d, expected %0d",
                                  rsp.woken_task, due.woken_task));
      end
    end
  end

  initial begin : drive_rsp_ready
    bit hold_done;
    int gap;
    hold_done = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!hold_done && reqs_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      if ($urandom_range(0, 9) < 7) repeat ($urandom_range(1, 12)) @(posedge clk);
      else repeat ($urandom_range(30, 120)) @(posedge clk);
      gap = idle_gap();
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    req_t       item;
    rsp_t       want;
    int         left;
    int         seg_len;
    int         acq_pct;
    int         dice;
    bit         eager;
    logic [3:0] hot_a;
    logic [3:0] hot_b;
    for (int r = 0; r < NUM_RESOURCES_DEF; r++) begin
      held[r] = 1'b0;
      holder[r] = '0;
      q_head[r] = 0;
      q_tail[r] = 0;
      q_count[r] = 0;
    end
    for (int s = 0; s < 5; s++) status_hits[s] = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      for (int k = 0; k < int'(directed[i].reps); k++) begin
        item.op = directed[i].op;
        item.task_id = directed[i].task_id + 6'(k);
        item.resource_id = directed[i].res;
        want.status = directed[i].status;
        want.woken_task = directed[i].woken;
        offer_request(item, 1'b0, directed[i].typed, want);
      end
    end

    // Segments lean on two busy resources so that queues fill, drain and wrap.
    left = RANDOM_ITEMS;
    want = '0;
    while (left > 0) begin
      seg_len = $urandom_range(20, 80);
      if (seg_len > left) seg_len = left;
      dice = $urandom_range(0, 2);
      acq_pct = (dice == 0) ? 80 : (dice == 1) ? 25 : 55;
      eager = ($urandom_range(0, 3) == 0);
      hot_a = 4'($urandom_range(0, 15));
      hot_b = 4'($urandom_range(0, 15));
      repeat (seg_len) begin
        item.op = ($urandom_range(0, 99) < acq_pct) ? OP_ACQUIRE : OP_RELEASE;
        dice = $urandom_range(0, 9);
        if (dice < 5) item.resource_id = hot_a;
        else if (dice < 8) item.resource_id = hot_b;
        else item.resource_id = 4'($urandom_range(0, 15));
        if (item.op == OP_RELEASE && $urandom_range(0, 1) == 1)
          item.task_id = holder[item.resource_id];
        else
          item.task_id = 6'($urandom_range(0, 63));
        offer_request(item, eager, 1'b0, want);
      end
      left -= seg_len;
    end
    req_valid <= 1'b0;

    while (due_wr != due_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d granted %0d queued %0d full %0d idle %0d handed over",
             reqs_taken, status_hits[ST_GRANTED], status_hits[ST_QUEUED],
             status_hits[ST_FULL], status_hits[ST_IDLE], status_hits[ST_HANDOVER]);
    $display("Deepest wait queue %0d of %0d after one %0d-cycle result stall, %0d mismatches.",
             deepest_queue, WAIT_DEPTH_DEF, HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/fmm_pkg.sv
rtl/core/fmm_res_store.sv
rtl/core/fmm_wait_ram.sv
rtl/core/fifo_mutex_manager.sv
tb/sv/tb_fifo_mutex_manager.sv
